// File: src/serial_console_line_editor_core_macros.svh
// Assertion macros for the serial console line editor.
`ifndef SERIAL_CONSOLE_LINE_EDITOR_CORE_MACROS_SVH
`define SERIAL_CONSOLE_LINE_EDITOR_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SCLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define SCLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/scle_pkg.sv
// Constants, types and character helpers shared by the serial console line editor.
`timescale 1ns / 1ps

package scle_pkg;

  localparam int LINE_CAPACITY = 32;
  localparam int FILL_W        = $clog2(LINE_CAPACITY);

  localparam int ECHO_MAX = 5;
  localparam int ECHO_CW  = $clog2(ECHO_MAX + 1);

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic DEST_TERM = 1'b0;
  localparam logic DEST_CMD  = 1'b1;

  typedef logic [ECHO_MAX-1:0][7:0] echo_buf_t;

  // Entry 0 goes out first.
  localparam echo_buf_t ECHO_EOL   = {CH_SPACE, CH_GT, CH_GT, CH_CR, CH_LF};
  localparam echo_buf_t ECHO_ERASE = {8'h00, 8'h00, CH_BS, CH_SPACE, CH_BS};

  function automatic logic is_eol(input logic [7:0] b);
    is_eol = (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_erase(input logic [7:0] b);
    is_erase = (b == CH_BS) || (b == CH_DEL);
  endfunction

  function automatic logic is_print(input logic [7:0] b);
    is_print = (b >= CH_SPACE) && (b <= CH_TILDE);
  endfunction

endpackage

// File: src/serial_console_line_editor_core.sv
// Serial console line editor: echo, line collection and handoff to the command side.
//
//  channel | direction | tdata       | tuser     | tlast
//  s_*     | in        | rx_byte     | kind      | -
//  m_*     | out       | out_byte    | dest      | last
//
// An item is taken, then its results go out one per cycle while the output is free.
// Line handoff reads the line store, whose read data is registered.
// Input is taken only while no results of the prior item are outstanding.
// Output stalls hold the sequencer. Synchronous reset clears all control state;
// the line store is not cleared (only written entries are ever read).
`timescale 1ns / 1ps

module serial_console_line_editor_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       s_tuser,   // [0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] dest
  output logic       m_tlast
);

  import scle_pkg::*;

  `include "serial_console_line_editor_core_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ECHO = 2'd1;
  localparam logic [1:0] S_PEND = 2'd2;
  localparam logic [1:0] S_LINE = 2'd3;

  logic [1:0]        state;
  logic              waiting;
  logic              pending_valid;
  logic [7:0]        pending_byte;
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] line_len;
  logic [FILL_W-1:0] rd_ptr;
  logic              line_dv;
  echo_buf_t         echo_buf;
  logic [ECHO_CW-1:0] echo_cnt;
  logic              echo_final;
  logic              redo;
  logic              line_go;

  logic              accept;
  logic              out_free;
  logic              echo_load;
  logic              line_load;
  logic              rd_issue;
  logic              dc_apply;
  logic [7:0]        dc_byte;
  echo_buf_t         dc_buf;
  logic [ECHO_CW-1:0] dc_cnt;
  logic              dc_line;
  logic              dc_wr;
  logic [FILL_W-1:0] dc_fill;
  logic [7:0]        ram_rdata;

  assign s_tready  = (state == S_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign echo_load = (state == S_ECHO) && out_free;
  assign line_load = (state == S_LINE) && line_dv && out_free;
  assign rd_issue  = (state == S_LINE) && (rd_ptr != line_len) && (!line_dv || line_load);

  // A received byte is edited now, or after a done event if it was held.
  assign dc_apply = (accept && (s_tuser == KIND_BYTE) && !waiting) || (state == S_PEND);
  assign dc_byte  = (state == S_PEND) ? pending_byte : s_tdata;

  always_comb begin
    dc_buf  = {ECHO_MAX{8'h00}};
    dc_cnt  = '0;
    dc_line = 1'b0;
    dc_wr   = 1'b0;
    dc_fill = fill_count;
    if (is_eol(dc_byte)) begin
      dc_buf = ECHO_EOL;
      if (fill_count != '0) begin
        dc_cnt  = ECHO_CW'(2);
        dc_line = 1'b1;
        dc_fill = '0;
      end else begin
        dc_cnt = ECHO_CW'(ECHO_MAX);
      end
    end else if (is_erase(dc_byte)) begin
      if (fill_count != '0) begin
        dc_buf  = ECHO_ERASE;
        dc_cnt  = ECHO_CW'(3);
        dc_fill = fill_count - 1'b1;
      end
    end else if (is_print(dc_byte)) begin
      dc_buf[0] = dc_byte;
      dc_cnt    = ECHO_CW'(1);
      dc_wr     = 1'b1;
      // full line: last slot is overwritten, count stays
      if (fill_count != FILL_W'(LINE_CAPACITY - 1)) begin
        dc_fill = fill_count + 1'b1;
      end
    end
  end

  // Writes happen only while editing, reads only during handoff: no overlap.
  scle_ram #(
    .WIDTH(8),
    .DEPTH(LINE_CAPACITY)
  ) u_line_store (
    .clk  (clk),
    .we   (dc_apply && dc_wr),
    .waddr(fill_count),
    .wdata(dc_byte),
    .re   (rd_issue),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      waiting       <= 1'b0;
      pending_valid <= 1'b0;
      pending_byte  <= 8'h00;
      fill_count    <= '0;
      rd_ptr        <= '0;
      line_dv       <= 1'b0;
      echo_cnt      <= '0;
      redo          <= 1'b0;
      line_go       <= 1'b0;
      echo_final    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !echo_load && !line_load) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept && waiting) begin
            if (s_tuser == KIND_BYTE) begin
              if (!pending_valid) begin
                pending_valid <= 1'b1;
                pending_byte  <= s_tdata;
              end
            end else begin
              echo_buf   <= ECHO_EOL;
              echo_cnt   <= ECHO_CW'(ECHO_MAX);
              waiting    <= 1'b0;
              redo       <= pending_valid;
              line_go    <= 1'b0;
              // prompt carries last unless the held byte yields output
              echo_final <= !(pending_valid &&
                              (is_print(pending_byte) || is_eol(pending_byte)));
              state      <= S_ECHO;
            end
          end
        end
        S_ECHO: begin
          if (echo_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= echo_buf[0];
            m_tuser  <= DEST_TERM;
            m_tlast  <= (echo_cnt == ECHO_CW'(1)) && echo_final;
            echo_buf <= {8'h00, echo_buf[ECHO_MAX-1:1]};
            echo_cnt <= echo_cnt - 1'b1;
            if (echo_cnt == ECHO_CW'(1)) begin
              state <= redo ? S_PEND : (line_go ? S_LINE : S_IDLE);
            end
          end
        end
        S_LINE: begin
          if (rd_issue) begin
            rd_ptr  <= rd_ptr + 1'b1;
            line_dv <= 1'b1;
          end else if (line_load) begin
            line_dv <= 1'b0;
          end
          if (line_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= ram_rdata;
            m_tuser  <= DEST_CMD;
            m_tlast  <= (rd_ptr == line_len);
            if (rd_ptr == line_len) begin
              state <= S_IDLE;
            end
          end
        end
        S_PEND: begin
          pending_valid <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (dc_apply) begin
        echo_buf   <= dc_buf;
        echo_cnt   <= dc_cnt;
        fill_count <= dc_fill;
        echo_final <= !dc_line;
        line_go    <= dc_line;
        redo       <= 1'b0;
        if (dc_line) begin
          line_len <= fill_count;
          rd_ptr   <= '0;
          waiting  <= 1'b1;
        end
        state <= (dc_cnt != '0) ? S_ECHO : S_IDLE;
      end
    end
  end

  `SCLE_ASSERT_NOW(a_wait_empty, waiting, fill_count == '0, "line not empty while waiting")
  `SCLE_ASSERT_NOW(a_idle_drained, s_tready, (echo_cnt == '0) && !line_dv, "idle with results left")
  `SCLE_ASSERT_NOW(a_held_byte, pending_valid && !waiting, redo || (state == S_PEND), "held byte lost")

endmodule

// File: src/scle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module scle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: tb/sv/tb_serial_console_line_editor_core.sv
// Self-checking testbench for the serial console line editor core.
`timescale 1ns / 1ps

module tb_serial_console_line_editor_core;
  import scle_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx;
    logic       hold;  // sender waits until all echo/line output is in
  } rx_item_t;

  typedef struct packed {
    logic       dest;
    logic [7:0] chr;
    logic       last;
  } tx_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  serial_console_line_editor_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rx_item_t rx_pending_q[$];
  tx_item_t console_out_q[$];
  rx_item_t cur_rx;
  bit       in_flight = 1'b0;

  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_lines    = 0;
  int n_overrun  = 0;
  int longest    = 0;

  // Editor state mirror
  bit                editing_blocked = 1'b0;
  logic [FILL_W-1:0] fill = '0;
  logic [7:0]        line_buf [LINE_CAPACITY];
  bit                parked_ok = 1'b0;
  logic [7:0]        parked_chr = 8'h00;

  // No idling on either side for a while in the middle of the run
  wire calm = (n_accepted >= 60) && (n_accepted < 110);

  task automatic queue_out(input logic dest, input logic [7:0] c);
    tx_item_t t;
    t.dest = dest;
    t.chr  = c;
    t.last = 1'b0;
    console_out_q.push_back(t);
  endtask

  task automatic queue_eol_prompt(input bit with_prompt);
    queue_out(DEST_TERM, CH_LF);
    queue_out(DEST_TERM, CH_CR);
    if (with_prompt) begin
      queue_out(DEST_TERM, CH_GT);
      queue_out(DEST_TERM, CH_GT);
      queue_out(DEST_TERM, CH_SPACE);
    end
  endtask

  task automatic edit_byte(input logic [7:0] b);
    if (b == CH_CR || b == CH_LF) begin
      if (fill != 0) begin
        queue_eol_prompt(1'b0);
        for (int i = 0; i < int'(fill); i++) queue_out(DEST_CMD, line_buf[i]);
        n_lines++;
        if (int'(fill) > longest) longest = int'(fill);
        fill = '0;
        editing_blocked = 1'b1;
      end else begin
        queue_eol_prompt(1'b1);
      end
    end else if (b == CH_BS || b == CH_DEL) begin
      if (fill != 0) begin
        queue_out(DEST_TERM, CH_BS);
        queue_out(DEST_TERM, CH_SPACE);
        queue_out(DEST_TERM, CH_BS);
        fill = fill - 1'b1;
      end
    end else if (b >= CH_SPACE && b <= CH_TILDE) begin
      queue_out(DEST_TERM, b);
      line_buf[fill] = b;
      if (int'(fill) < LINE_CAPACITY - 1) fill = fill + 1'b1;
      else n_overrun++;
    end
  endtask

  // Expected output for one accepted input transaction
  task automatic predict_console(input logic kind, input logic [7:0] b);
    int       n0;
    tx_item_t t;
    n0 = console_out_q.size();
    if (kind == KIND_BYTE) begin
      if (editing_blocked) begin
        if (!parked_ok) begin
          parked_ok  = 1'b1;
          parked_chr = b;
        end
      end else begin
        edit_byte(b);
      end
    end else if (editing_blocked) begin
      queue_eol_prompt(1'b1);
      editing_blocked = 1'b0;
      if (parked_ok) begin
        parked_ok = 1'b0;
        edit_byte(parked_chr);
      end
    end
    if (console_out_q.size() > n0) begin
      t = console_out_q.pop_back();
      t.last = 1'b1;
      console_out_q.push_back(t);
    end
  endtask

  // Sender
  always @(negedge clk) begin
    if (!rst && !in_flight) begin
      if (rx_pending_q.size() != 0 && !(rx_pending_q[0].hold && console_out_q.size() != 0) &&
          (calm || $urandom_range(99) >= 20)) begin
        cur_rx = rx_pending_q.pop_front();
        s_tuser  <= cur_rx.kind;
        s_tdata  <= cur_rx.rx;
        s_tvalid <= 1'b1;
        in_flight = 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_console(cur_rx.kind, cur_rx.rx);
      n_accepted++;
      in_flight = 1'b0;
    end
  end

  // Receiver stall
  always @(negedge clk) begin
    if (!rst) m_tready <= calm || ($urandom_range(99) >= 20);
  end

  // Output checker
  always @(posedge clk) begin
    tx_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (console_out_q.size() == 0) begin
        $display("%0t: unexpected output transaction dest=%0d byte=%02h last=%0d",
                 $time, m_tuser, m_tdata, m_tlast);
        n_errors++;
      end else begin
        want = console_out_q.pop_front();
        if (m_tuser !== want.dest || m_tdata !== want.chr || m_tlast !== want.last) begin
          $display({"%0t: mismatch expected dest=%0d byte=%02h last=%0d,",
                    " got dest=%0d byte=%02h last=%0d"},
                   $time, want.dest, want.chr, want.last, m_tuser, m_tdata, m_tlast);
          n_errors++;
        end
        n_checked++;
      end
    end
  end

  task automatic add_rx(input logic kind, input logic [7:0] b, input bit hold);
    rx_item_t it;
    it.kind = kind;
    it.rx   = b;
    it.hold = hold;
    rx_pending_q.push_back(it);
  endtask

  // One typed line with a terminator, optional typing while the command runs, then done
  task automatic gen_line(input bit hold);
    int         len;
    int         r;
    logic [7:0] c;
    len = ($urandom_range(99) < 15) ? $urandom_range(40, 28) : $urandom_range(8, 0);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 8) c = $urandom_range(1) ? CH_BS : CH_DEL;
      else if (r < 11) c = 8'($urandom_range(255));
      else c = 8'($urandom_range(CH_TILDE, CH_SPACE));
      add_rx(KIND_BYTE, c, hold && (i == 0));
    end
    add_rx(KIND_BYTE, $urandom_range(1) ? CH_CR : CH_LF, hold && (len == 0));
    if ($urandom_range(1)) begin
      r = $urandom_range(3, 1);
      for (int i = 0; i < r; i++) begin
        case ($urandom_range(3))
          0: c = 8'($urandom_range(255));
          1: c = $urandom_range(1) ? CH_CR : CH_BS;
          default: c = 8'($urandom_range(CH_TILDE, CH_SPACE));
        endcase
        add_rx(KIND_BYTE, c, 1'b0);
      end
    end
    add_rx(KIND_DONE, 8'($urandom_range(255)), 1'b0);
  endtask

  initial begin
    int r;
    // Directed: ignored events, empty-line cases, edits, handoff, typing while busy
    add_rx(KIND_DONE, 8'h00, 1'b0);
    add_rx(KIND_BYTE, CH_CR, 1'b0);
    add_rx(KIND_BYTE, CH_LF, 1'b0);
    add_rx(KIND_BYTE, CH_BS, 1'b0);
    add_rx(KIND_BYTE, CH_DEL, 1'b0);
    add_rx(KIND_BYTE, 8'h00, 1'b0);
    add_rx(KIND_BYTE, 8'hFF, 1'b0);
    add_rx(KIND_BYTE, 8'h1F, 1'b0);
    add_rx(KIND_BYTE, 8'h80, 1'b0);
    add_rx(KIND_BYTE, CH_SPACE, 1'b0);
    add_rx(KIND_BYTE, CH_TILDE, 1'b0);
    add_rx(KIND_BYTE, CH_DEL, 1'b0);
    add_rx(KIND_BYTE, "h", 1'b0);
    add_rx(KIND_BYTE, "i", 1'b0);
    add_rx(KIND_BYTE, CH_BS, 1'b0);
    add_rx(KIND_BYTE, "i", 1'b0);
    add_rx(KIND_BYTE, CH_CR, 1'b0);
    add_rx(KIND_BYTE, "x", 1'b1);
    add_rx(KIND_BYTE, "y", 1'b0);
    add_rx(KIND_BYTE, CH_BS, 1'b0);
    add_rx(KIND_DONE, 8'hA5, 1'b0);
    add_rx(KIND_BYTE, CH_LF, 1'b0);
    add_rx(KIND_DONE, 8'h5A, 1'b0);
    add_rx(KIND_DONE, 8'hFF, 1'b0);

    // Random: mostly well-formed lines, some noise
    while (rx_pending_q.size() < 200) begin
      r = $urandom_range(99);
      if (r < 85) begin
        gen_line($urandom_range(19) == 0);
      end else begin
        repeat ($urandom_range(3, 1)) begin
          if ($urandom_range(3) == 0) add_rx(KIND_DONE, 8'($urandom_range(255)), 1'b0);
          else add_rx(KIND_BYTE, 8'($urandom_range(255)), 1'b0);
        end
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (rx_pending_q.size() != 0 || in_flight) @(posedge clk);
    while (console_out_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (console_out_q.size() != 0) begin
      $display("%0t: %0d output transactions never arrived", $time, console_out_q.size());
      n_errors++;
    end
    $display("run: %0d input and %0d output transactions, %0d lines handed off (longest %0d)",
             n_accepted, n_checked, n_lines, longest);
    $display("run: %0d writes into the last slot of a full line, %0d errors", n_overrun, n_errors);
    if (n_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/scle_pkg.sv
src/scle_ram.sv
src/serial_console_line_editor_core.sv
tb/sv/tb_serial_console_line_editor_core.sv
